// ===== sv/dlas_pkg.sv =====
package dlas_pkg;

   // Timestamp width (the time input is fixed at 32 bits)
   localparam int TIME_W = 32;
   // Config register width and count
   localparam int CFG_W = 16;
   localparam int CFG_N = 7;
   localparam int CFG_IDX_W = 3;
   // Widest timeout sum: four 16-bit terms
   localparam int LIM_W = CFG_W + 2;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_DEBOUNCE    = 3'd0,
      REG_CLOSE_DELAY = 3'd1,
      REG_CLOSE_DRIVE = 3'd2,
      REG_PARK_DRIVE  = 3'd3,
      REG_OPEN_DELAY  = 3'd4,
      REG_OPEN_DRIVE  = 3'd5,
      REG_OPEN_HOLD   = 3'd6
   } reg_idx_type;

   localparam logic [CFG_W-1:0] RST_DEBOUNCE = 16'd20;
   localparam logic [CFG_W-1:0] RST_DRIVE    = 16'd1500;
   localparam logic [CFG_W-1:0] RST_SHORT    = 16'd1000;

   typedef struct packed {
      logic [CFG_W-1:0] debounce;
      logic [CFG_W-1:0] close_delay;
      logic [CFG_W-1:0] close_drive;
      logic [CFG_W-1:0] park_drive;
      logic [CFG_W-1:0] open_delay;
      logic [CFG_W-1:0] open_drive;
      logic [CFG_W-1:0] open_hold;
   } cfg_type;

   typedef enum logic [1:0] {
      LK_UNDEF  = 2'd0,
      LK_OPENED = 2'd1,
      LK_PUSHED = 2'd2,
      LK_CLOSED = 2'd3
   } lock_type;

   typedef enum logic [1:0] {
      DRV_STOP  = 2'd0,
      DRV_CLOSE = 2'd1,
      DRV_OPEN  = 2'd2
   } drive_type;

   typedef enum logic [1:0] {
      MODE_WAIT  = 2'd0,
      MODE_CLOSE = 2'd1,
      MODE_OPEN  = 2'd2
   } mode_type;

   typedef enum logic [4:0] {
      PH_WAIT   = 5'b00001,
      PH_CLOSE  = 5'b00010,
      PH_PARK_C = 5'b00100,
      PH_OPEN   = 5'b01000,
      PH_PARK_O = 5'b10000
   } phase_type;

   typedef struct packed {
      drive_type drive;
      mode_type  mode;
   } seq_out_type;

endpackage

// ===== sv/dlas_csr.sv =====
module dlas_csr
   import dlas_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (reg_idx_type'(csr_index))
            REG_DEBOUNCE:    cfg_in.debounce    = csr_wdata;
            REG_CLOSE_DELAY: cfg_in.close_delay = csr_wdata;
            REG_CLOSE_DRIVE: cfg_in.close_drive = csr_wdata;
            REG_PARK_DRIVE:  cfg_in.park_drive  = csr_wdata;
            REG_OPEN_DELAY:  cfg_in.open_delay  = csr_wdata;
            REG_OPEN_DRIVE:  cfg_in.open_drive  = csr_wdata;
            REG_OPEN_HOLD:   cfg_in.open_hold   = csr_wdata;
            default:         cfg_in = cfg_ff;  // index 7 ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce    <= RST_DEBOUNCE;
         cfg_ff.close_delay <= RST_DRIVE;
         cfg_ff.close_drive <= RST_DRIVE;
         cfg_ff.park_drive  <= RST_DRIVE;
         cfg_ff.open_delay  <= RST_SHORT;
         cfg_ff.open_drive  <= RST_DRIVE;
         cfg_ff.open_hold   <= RST_SHORT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/dlas_debounce.sv =====
module dlas_debounce
   import dlas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [TIME_W-1:0] now,
   input  logic              closed_sw,
   input  logic              pushed_sw,
   input  logic [CFG_W-1:0]  debounce,
   output lock_type          lock
);

   logic [TIME_W-1:0] last_time_ff, last_time_in;
   logic [1:0]        prev_ff, prev_in;
   logic [1:0]        reg_ff, reg_in;
   logic [TIME_W-1:0] since;
   logic [1:0]        act;
   logic              take;

   assign since = now - last_time_ff;
   assign act   = {closed_sw, pushed_sw};
   assign take  = since > {{(TIME_W-CFG_W){1'b0}}, debounce};

   always_comb begin
      last_time_in = last_time_ff;
      prev_in      = prev_ff;
      reg_in       = reg_ff;
      if (take) begin
         last_time_in = now;
         prev_in      = act;
         if (act == prev_ff) reg_in = act;
      end
   end

   // decode of the updated sample: {closed, pushed}
   always_comb begin
      unique case (reg_in)
         2'b00:   lock = LK_OPENED;
         2'b01:   lock = LK_PUSHED;
         2'b11:   lock = LK_CLOSED;
         default: lock = LK_UNDEF;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         prev_ff      <= '0;
         reg_ff       <= '0;
      end else if (advance) begin
         last_time_ff <= last_time_in;
         prev_ff      <= prev_in;
         reg_ff       <= reg_in;
      end
   end

endmodule

// ===== sv/dlas_seq.sv =====
module dlas_seq
   import dlas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cfg_type           cfg,
   input  logic [TIME_W-1:0] now,
   input  lock_type          lock,
   input  logic              parking_sw,
   input  logic              button,
   output seq_out_type       seq_out
);

   phase_type         phase_ff, phase_in;
   logic [TIME_W-1:0] start_ff, start_in;
   drive_type         drive_ff, drive_in;

   logic [TIME_W-1:0] el;
   logic [LIM_W-1:0]  lim_close, lim_park_c, lim_open, lim_hold, lim_park_o;

   // timeout sums never wrap: 18 bits hold four 16-bit terms
   assign lim_close  = LIM_W'(cfg.close_delay) + LIM_W'(cfg.close_drive);
   assign lim_park_c = lim_close + LIM_W'(cfg.park_drive);
   assign lim_open   = LIM_W'(cfg.open_delay) + LIM_W'(cfg.open_drive);
   assign lim_hold   = lim_open + LIM_W'(cfg.open_hold);
   assign lim_park_o = lim_hold + LIM_W'(cfg.park_drive);

   assign el = now - start_ff;

   function automatic logic past(input logic [TIME_W-1:0] e, input logic [LIM_W-1:0] l);
      past = e > {{(TIME_W-LIM_W){1'b0}}, l};
   endfunction

   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      drive_in = drive_ff;
      unique case (phase_ff)
         PH_CLOSE: begin
            if (el >= TIME_W'(cfg.close_delay)) begin
               drive_in = DRV_CLOSE;
               if (lock == LK_CLOSED || past(el, lim_close)) begin
                  drive_in = DRV_STOP;
                  phase_in = PH_PARK_C;
               end
            end
         end
         PH_PARK_C: begin
            drive_in = DRV_OPEN;
            if (!parking_sw || past(el, lim_park_c)) begin
               drive_in = DRV_STOP;
               phase_in = PH_WAIT;
            end
         end
         PH_OPEN: begin
            if (el >= TIME_W'(cfg.open_delay)) begin
               if (lock == LK_OPENED || past(el, lim_open)) begin
                  drive_in = DRV_STOP;
                  if (past(el, lim_hold)) phase_in = PH_PARK_O;
               end else begin
                  drive_in = DRV_OPEN;
               end
            end
         end
         PH_PARK_O: begin
            drive_in = DRV_CLOSE;
            if (!parking_sw || past(el, lim_park_o)) begin
               drive_in = DRV_STOP;
               phase_in = PH_WAIT;
            end
         end
         default: begin
            phase_in = PH_WAIT;
            if (lock == LK_PUSHED) begin
               phase_in = PH_CLOSE;
               start_in = now;
            end else if (lock == LK_CLOSED && !button) begin
               phase_in = PH_OPEN;
               start_in = now;
            end
         end
      endcase
   end

   always_comb begin
      seq_out.drive = drive_in;
      unique case (phase_in)
         PH_CLOSE, PH_PARK_C: seq_out.mode = MODE_CLOSE;
         PH_OPEN, PH_PARK_O:  seq_out.mode = MODE_OPEN;
         default:             seq_out.mode = MODE_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         start_ff <= '0;
         drive_ff <= DRV_STOP;
      end else if (advance) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         drive_ff <= drive_in;
      end
   end

   phase_onehot_a: assert property (@(posedge clock) disable iff (reset)
      $onehot(phase_ff))
      else $error("phase register not one-hot");

   wait_stopped_a: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WAIT |-> drive_ff == DRV_STOP)
      else $error("motor driven while waiting");

   park_c_exit_a: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == PH_PARK_C |=> phase_ff == PH_PARK_C || phase_ff == PH_WAIT)
      else $error("bad exit from parking after close");

endmodule

// ===== sv/door_lock_actuator_sequencer_top.sv =====
// Channel | Ports                                                   | Direction
// req     | req_valid/ready, time_now_ms, 4 switch/button levels    | in
// rsp     | rsp_valid/ready, motor_drive, lock_state, mode          | out
// csr     | csr_wr_en, csr_index, csr_wdata (16 b, write only)      | in
//
// One poll per clock unless a stalled rsp holds the result register. A beat
// is captured in the input register, then the debounce and sequencer logic
// computes combinationally into the result register, which drives rsp_valid.
// Synchronous active-high reset restores default timings and waiting mode.
// A stalled rsp holds the result register; the input register still takes one
// more beat, then req_ready stays low until rsp_ready returns (two beats held).
module door_lock_actuator_sequencer_top
   import dlas_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [TIME_W-1:0]    req_time_now_ms,
   input  logic                 req_closed_switch,
   input  logic                 req_pushed_switch,
   input  logic                 req_parking_switch,
   input  logic                 req_open_button,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_motor_drive,
   output logic [1:0]           rsp_lock_state,
   output logic [1:0]           rsp_mode,

   input  logic                 csr_wr_en,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   cfg_type     cfg;
   lock_type    lock;
   seq_out_type seq_out;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   logic [TIME_W-1:0] s1_time_ff;
   logic              s1_closed_ff, s1_pushed_ff, s1_parking_ff, s1_button_ff;

   // result stage
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        drive_ff, lock_ff, mode_ff;

   logic advance;
   logic req_take;

   // beat moves to the result register when that register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   dlas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dlas_debounce u_debounce (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .now       (s1_time_ff),
      .closed_sw (s1_closed_ff),
      .pushed_sw (s1_pushed_ff),
      .debounce  (cfg.debounce),
      .lock      (lock)
   );

   dlas_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cfg        (cfg),
      .now        (s1_time_ff),
      .lock       (lock),
      .parking_sw (s1_parking_ff),
      .button     (s1_button_ff),
      .seq_out    (seq_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_time_ff    <= req_time_now_ms;
         s1_closed_ff  <= req_closed_switch;
         s1_pushed_ff  <= req_pushed_switch;
         s1_parking_ff <= req_parking_switch;
         s1_button_ff  <= req_open_button;
      end
      if (advance) begin
         drive_ff <= seq_out.drive;
         lock_ff  <= lock;
         mode_ff  <= seq_out.mode;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_motor_drive = drive_ff;
   assign rsp_lock_state  = lock_ff;
   assign rsp_mode        = mode_ff;

   stall_full_a: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff)
      else $error("req stalled with a free stage");

   drive_mode_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && drive_ff != DRV_STOP |-> mode_ff != MODE_WAIT)
      else $error("motor driven in waiting mode");

   advance_fills_a: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed beat lost");

endmodule
